@@ rtl/ps2mpt_pkg.sv @@
package ps2mpt_pkg;

  // Packet header byte layout
  localparam int unsigned HDR_SYNC_BIT = 3;
  localparam int unsigned BTN_W        = 3;
  localparam int unsigned BYTE_W       = 8;

  // Fixed result field widths
  localparam int unsigned CUR_W = 10;
  localparam int unsigned COL_W = 7;
  localparam int unsigned ROW_W = 5;

  // Output tdata layout, lowest bit first
  localparam int unsigned OFS_X     = 0;
  localparam int unsigned OFS_Y     = OFS_X + CUR_W;
  localparam int unsigned OFS_BTN   = OFS_Y + CUR_W;
  localparam int unsigned OFS_CLICK = OFS_BTN + BTN_W;
  localparam int unsigned OFS_DRAG  = OFS_CLICK + 1;
  localparam int unsigned OFS_SCOL  = OFS_DRAG + 1;
  localparam int unsigned OFS_SROW  = OFS_SCOL + COL_W;
  localparam int unsigned OFS_ECOL  = OFS_SROW + ROW_W;
  localparam int unsigned OFS_EROW  = OFS_ECOL + COL_W;
  localparam int unsigned OUT_USED  = OFS_EROW + ROW_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_USED + 7) / 8) * 8;

  // Position within the three-byte packet
  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_DX   = 3'b010,
    PH_DY   = 3'b100
  } phase_e;

  // Per-transaction flags passed from the state update to the result stage
  typedef struct packed {
    logic             click;
    logic             done;
    logic             drag;
    logic             start_upd;
    logic             end_upd;
    logic [BTN_W-1:0] buttons;
  } flags_t;

endpackage

@@ rtl/ps2mpt_cell.sv @@
module ps2mpt_cell #(
  parameter int unsigned PIXELS = 1024,
  parameter int unsigned CELLS  = 80,
  localparam int unsigned PW = $clog2(PIXELS),
  localparam int unsigned CW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
  input  logic [PW-1:0] pos_i,
  output logic [CW-1:0] cell_o
);

  // floor(pos*CELLS/PIXELS) as one multiply by a rounded-up reciprocal.
  // Exact while pos*err < 2^SH, which holds for pos, err < 2^PW.
  localparam int unsigned      SH    = 2 * PW;
  localparam longint unsigned  RECIP = ((64'(CELLS) << SH) + 64'(PIXELS) - 64'd1)
                                       / 64'(PIXELS);
  localparam int unsigned      RW    = $clog2(RECIP + 64'd1);
  localparam int unsigned      MW    = PW + RW;

  logic [MW-1:0] prod;
  logic [MW-1:0] quot;

  assign prod   = MW'(pos_i) * MW'(RECIP);
  assign quot   = prod >> SH;
  assign cell_o = (quot > MW'(CELLS - 1)) ? CW'(CELLS - 1) : CW'(quot);

endmodule

@@ rtl/ps2_mouse_packet_tracker_unit.sv @@
// Channel    | Dir | Signals                          | Contents
// -----------+-----+----------------------------------+------------------------------------
// byte in    | in  | s_axis_tvalid/tready/tdata[7:0]  | raw mouse byte
// result out | out | m_axis_tvalid/tready/tdata/tlast | cursor, buttons, drag cells; tlast
//            |     |                                  | marks the byte that ends a packet
// config     | in  | cfg_wen_i, cfg_wdata_i           | enable bit
//
// One byte per cycle sustained while the output is not stalled. Each transaction
// passes two register stages: the packet state update (phase, delta, cursor add
// and clamp, buttons) into the middle register, then the text-cell conversion
// (one constant multiply per axis) into the output register.
// Reset (async, active low) puts the cursor mid-screen, disables the block and
// clears the drag cells. A stalled output holds the pipe: bytes are taken only
// while the middle stage can move on.
module ps2_mouse_packet_tracker_unit
  import ps2mpt_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 1024,
  parameter int unsigned SCREEN_HEIGHT = 768,
  parameter int unsigned TEXT_COLS     = 80,
  parameter int unsigned TEXT_ROWS     = 25
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_wen_i,
  input  logic                   cfg_wdata_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [BYTE_W-1:0]      s_axis_tdata,   // [7:0] data_byte
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [9:0] cursor_x, [19:10] cursor_y, [22:20] button_bits, [23] click_pulse,
  // [24] dragging, [31:25] drag_start_col, [36:32] drag_start_row,
  // [43:37] drag_end_col, [48:44] drag_end_row, [55:49] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   m_axis_tlast    // packet_done
);

  localparam int unsigned XW  = $clog2(SCREEN_WIDTH);
  localparam int unsigned YW  = $clog2(SCREEN_HEIGHT);
  localparam int unsigned CCW = (TEXT_COLS > 1) ? $clog2(TEXT_COLS) : 1;
  localparam int unsigned RCW = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
  // sum width: wide enough for the position and a full signed byte delta
  localparam int unsigned NXW = ((XW > BYTE_W) ? XW : BYTE_W) + 2;
  localparam int unsigned NYW = ((YW > BYTE_W) ? YW : BYTE_W) + 2;

  // ---------------- handshake ----------------
  logic mid_v_q, out_v_q;
  logic out_adv, mid_adv, s_acc;

  assign out_adv       = mid_v_q && (!out_v_q || m_axis_tready);
  assign mid_adv       = !mid_v_q || out_adv;
  assign s_axis_tready = mid_adv;
  assign s_acc         = s_axis_tvalid && mid_adv;

  // ---------------- configuration ----------------
  logic enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (cfg_wen_i) begin
      enable_q <= cfg_wdata_i;
    end
  end

  // ---------------- stage A: packet state ----------------
  phase_e            phase_q, phase_d;
  logic [BYTE_W-1:0] dx_q, dx_d;
  logic [XW-1:0]     x_q, x_d;
  logic [YW-1:0]     y_q, y_d;
  logic [BTN_W-1:0]  btn_q, btn_d;
  logic              drag_q, drag_d;
  flags_t            flags_d;

  logic signed [NXW-1:0] nx;
  logic signed [NYW-1:0] ny;

  // Deltas are 8-bit two's complement; Y grows downward on screen.
  assign nx = $signed(NXW'(x_q)) + NXW'($signed(dx_q));
  assign ny = $signed(NYW'(y_q)) - NYW'($signed(s_axis_tdata));

  always_comb begin
    phase_d = phase_q;
    dx_d    = dx_q;
    x_d     = x_q;
    y_d     = y_q;
    btn_d   = btn_q;
    drag_d  = drag_q;
    flags_d = '0;
    if (s_acc && enable_q) begin
      case (phase_q)
        PH_DX: begin
          dx_d    = s_axis_tdata;
          phase_d = PH_DY;
        end
        PH_DY: begin
          if (nx < 0) begin
            x_d = '0;
          end else if (nx > $signed(NXW'(SCREEN_WIDTH - 1))) begin
            x_d = XW'(SCREEN_WIDTH - 1);
          end else begin
            x_d = XW'(nx);
          end
          if (ny < 0) begin
            y_d = '0;
          end else if (ny > $signed(NYW'(SCREEN_HEIGHT - 1))) begin
            y_d = YW'(SCREEN_HEIGHT - 1);
          end else begin
            y_d = YW'(ny);
          end
          phase_d         = PH_HEAD;
          flags_d.done    = 1'b1;
          flags_d.end_upd = drag_q;
        end
        default: begin
          // header byte; without the sync bit it is dropped (resync)
          phase_d = PH_HEAD;
          if (s_axis_tdata[HDR_SYNC_BIT]) begin
            btn_d         = s_axis_tdata[BTN_W-1:0];
            flags_d.click = (btn_q == '0) && (s_axis_tdata[BTN_W-1:0] != '0);
            if (s_axis_tdata[0]) begin
              if (!drag_q) begin
                drag_d            = 1'b1;
                flags_d.start_upd = 1'b1;
              end
            end else begin
              drag_d = 1'b0;
            end
            phase_d = PH_DX;
          end
        end
      endcase
    end
    flags_d.drag    = drag_d;
    flags_d.buttons = btn_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      dx_q    <= '0;
      x_q     <= XW'(SCREEN_WIDTH / 2);
      y_q     <= YW'(SCREEN_HEIGHT / 2);
      btn_q   <= '0;
      drag_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      dx_q    <= dx_d;
      x_q     <= x_d;
      y_q     <= y_d;
      btn_q   <= btn_d;
      drag_q  <= drag_d;
    end
  end

  // Middle register: snapshot of the post-update state for this transaction
  flags_t        mid_flags_q;
  logic [XW-1:0] mid_x_q;
  logic [YW-1:0] mid_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
    end else if (mid_adv) begin
      mid_v_q <= s_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      mid_flags_q <= flags_d;
      mid_x_q     <= x_d;
      mid_y_q     <= y_d;
    end
  end

  // ---------------- stage B: text cells and result ----------------
  logic [CCW-1:0] col;
  logic [RCW-1:0] row;

  ps2mpt_cell #(.PIXELS(SCREEN_WIDTH), .CELLS(TEXT_COLS)) u_col (
    .pos_i  (mid_x_q),
    .cell_o (col)
  );

  ps2mpt_cell #(.PIXELS(SCREEN_HEIGHT), .CELLS(TEXT_ROWS)) u_row (
    .pos_i  (mid_y_q),
    .cell_o (row)
  );

  logic [CCW-1:0] scol_q, scol_d, ecol_q, ecol_d;
  logic [RCW-1:0] srow_q, srow_d, erow_q, erow_d;

  // Pointer has not moved on a header byte, so the snapshot gives the start cell.
  assign scol_d = mid_flags_q.start_upd ? col : scol_q;
  assign srow_d = mid_flags_q.start_upd ? row : srow_q;
  assign ecol_d = mid_flags_q.end_upd   ? col : ecol_q;
  assign erow_d = mid_flags_q.end_upd   ? row : erow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scol_q  <= '0;
      srow_q  <= '0;
      ecol_q  <= '0;
      erow_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (out_adv) begin
        scol_q <= scol_d;
        srow_q <= srow_d;
        ecol_q <= ecol_d;
        erow_q <= erow_d;
      end
      if (out_adv) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  logic [OUT_TDATA_W-1:0] tdata_q;
  logic                   tlast_q;

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      tdata_q <= {
        (OUT_TDATA_W - OUT_USED)'(0),
        ROW_W'(erow_d),
        COL_W'(ecol_d),
        ROW_W'(srow_d),
        COL_W'(scol_d),
        mid_flags_q.drag,
        mid_flags_q.click,
        mid_flags_q.buttons,
        CUR_W'(mid_y_q),
        CUR_W'(mid_x_q)
      };
      tlast_q <= mid_flags_q.done;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tlast  = tlast_q;

endmodule

@@ rtl/ps2mpt_checker.sv @@
module ps2mpt_checker
  import ps2mpt_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = 1024,
  parameter int unsigned SCREEN_HEIGHT = 768
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  logic             click;
  logic             drag;
  logic [BTN_W-1:0] btn;
  logic [CUR_W-1:0] cx;
  logic [CUR_W-1:0] cy;

  assign click = m_axis_tdata[OFS_CLICK];
  assign drag  = m_axis_tdata[OFS_DRAG];
  assign btn   = m_axis_tdata[OFS_BTN +: BTN_W];
  assign cx    = m_axis_tdata[OFS_X +: CUR_W];
  assign cy    = m_axis_tdata[OFS_Y +: CUR_W];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // a click comes from a header byte, a packet end from a Y byte
  a_click_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(click && m_axis_tlast))
    else $error("click and packet end in one transaction");

  a_click_btn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && click |-> btn != '0)
    else $error("click without a pressed button");

  a_click_drag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && click && btn[0] |-> drag)
    else $error("left click did not start a drag");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(cx) < SCREEN_WIDTH) && (32'(cy) < SCREEN_HEIGHT))
    else $error("cursor off screen");

endmodule

bind ps2_mouse_packet_tracker_unit ps2mpt_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_ps2mpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
